// ===== rtl/tks_pkg.sv =====
// Package for the top-k score selector: constants, types and float compare.
package tks_pkg;
  localparam int MAX_KEPT    = 8;
  localparam int MAX_SET_LEN = 256;
  localparam int SLOT_W      = $clog2(MAX_KEPT);
  localparam int KCNT_W      = $clog2(MAX_KEPT + 1);
  localparam int SETPOS_W    = $clog2(MAX_SET_LEN + 1);
  localparam int POS_W       = 9;
  localparam int K_W         = 4;
  localparam int ADDR_W      = 1;
  localparam logic [31:0]      NEG_INF_BITS = 32'hFF80_0000;
  localparam logic [POS_W-1:0] NO_POSITION  = '1;
  localparam logic [ADDR_W-1:0] REG_K_SELECTED = '0;
  localparam logic [K_W-1:0]   K_RESET = 4'd4;

  typedef struct packed {
    logic [31:0]      score;
    logic [POS_W-1:0] pos;
  } slot_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // C float a < b
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic az;
    logic bz;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (az && bz) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction
endpackage

// ===== rtl/top_k_score_selector.sv =====
// Top level of the top-k score selector: slot memory, minimum search, emit.
//
// channel  dir  handshake         payload
// s_axis   in   tvalid/tready     tdata score_bits, tuser final_score
// m_axis   out  tvalid/tready     tdata kept_score_bits,kept_position; tlast final_result
// apb      in   psel/penable      k_selected at address 0
//
// Fill-phase item: written straight into the slot memory as it is accepted.
// Later item: the single read port scans one slot a cycle over the k slots, then the
// last compare is made, then the replacement is written back in the DEC state.
// A final item then emits one item per slot after a first read, each
// held while the output register is stalled. Re-arming clears a valid bit per slot.
module top_k_score_selector
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] score_bits
  input  logic              s_axis_tuser,   // [0] final_score
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // [31:0] kept_score_bits, [40:32] kept_position
  output logic              m_axis_tlast,   // final_result
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [1:0] ST_IDLE = 2'd0, ST_SCAN = 2'd1, ST_DEC = 2'd2, ST_EMIT = 2'd3;

  logic [K_W-1:0]      k_selected;
  logic [1:0]          state;
  slot_t               mem [MAX_KEPT];
  slot_t               rd;
  logic [MAX_KEPT-1:0] valid;
  logic [SETPOS_W-1:0] set_pos;
  logic [31:0]         score;
  logic [POS_W-1:0]    pos;
  logic                last;
  logic [SLOT_W-1:0]   raddr;
  logic [SLOT_W-1:0]   scan_idx;
  logic                scan_done;
  logic                rd_ok;
  logic [SLOT_W-1:0]   rd_idx;
  logic [SLOT_W-1:0]   sel_idx;
  logic [31:0]         min_val;
  logic [SLOT_W-1:0]   min_idx;
  logic                min_have;
  logic [KCNT_W-1:0]   k_eff;
  logic                idx_last;
  logic                fill_take;
  logic                we;
  logic [SLOT_W-1:0]   waddr;
  slot_t               wdata;
  logic [31:0]         rd_score;
  logic [POS_W-1:0]    rd_pos;
  logic                out_free;
  logic                emit_take;

  always_comb begin
    if (k_selected == '0) k_eff = KCNT_W'(1);
    else if (KCNT_W'(k_selected) > KCNT_W'(MAX_KEPT)) k_eff = KCNT_W'(MAX_KEPT);
    else k_eff = KCNT_W'(k_selected);
  end

  assign pready = 1'b1;
  assign prdata = {{(32 - K_W){1'b0}}, k_selected};
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign idx_last = (KCNT_W'(scan_idx) + KCNT_W'(1)) == k_eff;
  assign fill_take = (state == ST_IDLE) && s_axis_tvalid
                     && (set_pos < SETPOS_W'(MAX_SET_LEN)) && (set_pos < SETPOS_W'(k_eff));
  assign emit_take = (state == ST_EMIT) && rd_ok && out_free;
  assign raddr = emit_take ? scan_idx + SLOT_W'(1) : scan_idx;
  assign sel_idx = (state == ST_EMIT) ? scan_idx : rd_idx;
  assign rd_score = valid[sel_idx] ? rd.score : NEG_INF_BITS;
  assign rd_pos   = valid[sel_idx] ? rd.pos : NO_POSITION;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_selected <= K_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == REG_K_SELECTED) k_selected <= pwdata[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_comb begin
    we    = 1'b0;
    waddr = min_idx;
    wdata = '{score: score, pos: pos};
    if (fill_take) begin
      we    = 1'b1;
      waddr = SLOT_W'(set_pos);
      wdata = '{score: s_axis_tdata, pos: POS_W'(set_pos)};
    end else if (state == ST_DEC && flt_lt(min_val, score)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      set_pos   <= '0;
      rd_ok     <= 1'b0;
      scan_idx  <= '0;
      scan_done <= 1'b0;
      min_have  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            score     <= s_axis_tdata;
            last      <= s_axis_tuser;
            pos       <= POS_W'(set_pos);
            scan_idx  <= '0;
            scan_done <= 1'b0;
            min_have  <= 1'b0;
            rd_ok     <= 1'b0;
            if (set_pos < SETPOS_W'(MAX_SET_LEN)) begin
              set_pos <= set_pos + SETPOS_W'(1);
              if (set_pos < SETPOS_W'(k_eff)) begin
                valid[SLOT_W'(set_pos)] <= 1'b1;
                if (s_axis_tuser) state <= ST_EMIT;
              end else begin
                state <= ST_SCAN;
              end
            end else if (s_axis_tuser) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          if (rd_ok) begin
            if (!min_have || flt_lt(rd_score, min_val)) begin
              min_val <= rd_score;
              min_idx <= rd_idx;
            end
            min_have <= 1'b1;
          end
          if (!scan_done) begin
            rd_ok  <= 1'b1;
            rd_idx <= scan_idx;
            if (idx_last) scan_done <= 1'b1;
            else scan_idx <= scan_idx + SLOT_W'(1);
          end else begin
            rd_ok <= 1'b0;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (we) valid[min_idx] <= 1'b1;
          scan_idx <= '0;
          state    <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (out_free) begin
            if (idx_last) begin
              rd_ok    <= 1'b0;
              scan_idx <= '0;
              valid    <= '0;
              set_pos  <= '0;
              state    <= ST_IDLE;
            end else begin
              scan_idx <= scan_idx + SLOT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_take) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {7'd0, rd_pos, rd_score};
      m_axis_tlast  <= idx_last;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");
  a_setpos: assert property (@(posedge clk) disable iff (rst)
    set_pos <= SETPOS_W'(MAX_SET_LEN)) else $error("set position overflow");
  a_k_eff: assert property (@(posedge clk) disable iff (rst)
    (k_eff != '0) && (k_eff <= KCNT_W'(MAX_KEPT))) else $error("slot count out of range");
endmodule

// ===== bench/top_k_score_selector_checker.sv =====
// Checker for the top-k score selector: tracks slots, predicts emitted items, compares.
`timescale 1ns / 1ps
module top_k_score_selector_checker
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [47:0]       m_axis_tdata,
  input  logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                pending,
  output int                errors
);
  typedef struct packed {
    logic [31:0]      score;
    logic [POS_W-1:0] pos;
    logic             last;
  } kept_t;

  kept_t            kept_q[$];
  logic [31:0]      slot_score[MAX_KEPT];
  logic [POS_W-1:0] slot_pos[MAX_KEPT];
  int               set_pos;
  logic [K_W-1:0]   k_reg;

  assign pending = kept_q.size();

  // C float a < b, via a monotonic integer key
  function automatic bit score_less(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
      return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    if (k_reg > MAX_KEPT) return MAX_KEPT;
    return int'(k_reg);
  endfunction

  task automatic rearm_slots();
    for (int i = 0; i < MAX_KEPT; i++) begin
      slot_score[i] = NEG_INF_BITS;
      slot_pos[i]   = NO_POSITION;
    end
    set_pos = 0;
  endtask

  task automatic take_score(input logic [31:0] score, input logic last);
    int   k;
    int   min_i;
    kept_t e;
    k = eff_k();
    if (set_pos < MAX_SET_LEN) begin
      if (set_pos < k) begin
        slot_score[set_pos] = score;
        slot_pos[set_pos]   = set_pos[POS_W-1:0];
      end else begin
        min_i = 0;
        for (int i = 1; i < k; i++)
          if (score_less(slot_score[i], slot_score[min_i])) min_i = i;
        if (score_less(slot_score[min_i], score)) begin
          slot_score[min_i] = score;
          slot_pos[min_i]   = set_pos[POS_W-1:0];
        end
      end
      set_pos++;
    end
    if (last) begin
      for (int i = 0; i < k; i++) begin
        e.score = slot_score[i];
        e.pos   = slot_pos[i];
        e.last  = (i == k - 1);
        kept_q.push_back(e);
      end
      rearm_slots();
    end
  endtask

  initial begin
    errors = 0;
    k_reg  = K_RESET;
    rearm_slots();
  end

  always @(posedge clk) begin
    kept_t e;
    if (rst) begin
      k_reg = K_RESET;
      rearm_slots();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_K_SELECTED)
        k_reg = pwdata[K_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        take_score(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (kept_q.size() == 0) begin
          $error("unexpected item: score %h position %h", m_axis_tdata[31:0],
                 m_axis_tdata[40:32]);
          errors++;
        end else begin
          e = kept_q.pop_front();
          if (m_axis_tdata[31:0] !== e.score) begin
            $error("kept_score_bits expected %h actual %h", e.score, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[40:32] !== e.pos) begin
            $error("kept_position expected %h actual %h", e.pos, m_axis_tdata[40:32]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("final_result expected %b actual %b", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ===== bench/top_k_score_selector_tb.sv =====
// Testbench top for the top-k score selector: stimulus, idling, watchdog, verdict.
`timescale 1ns / 1ps
module top_k_score_selector_tb
  import tks_pkg::*;
();

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;   // [31:0] score_bits
  logic              s_axis_tuser;   // [0] final_score
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // [31:0] kept_score_bits, [40:32] kept_position
  logic              m_axis_tlast;   // final_result
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int pending;
  int errors;
  int idle_pct;
  int stall_pct;
  int quiet;
  int sent;
  bit hold_req;
  logic [31:0] tie_pool[6];

  top_k_score_selector uut (.*);

  top_k_score_selector_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("top_k_score_selector regression: fail");
      $finish;
    end
  end

  task automatic send_score(input logic [31:0] score, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= score;
    s_axis_tuser  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent++;
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // only while idle: no item pending, and the block has drained its last item
  task automatic write_k(input logic [3:0] k);
    drop_valid();
    wait (pending == 0);
    @(negedge clk);
    repeat (24) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_K_SELECTED;
    pwdata  <= {28'd0, k};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_score();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom;
    if (r < 80) return tie_pool[$urandom_range(5)];
    case ($urandom_range(7))
      0: return 32'h7F80_0000;
      1: return 32'hFF80_0000;
      2: return 32'h7FC0_0000 | $urandom_range(32'h3F_FFFF);
      3: return 32'hFF80_0001;
      4: return 32'h0000_0000;
      5: return 32'h8000_0000;
      6: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      default: return {1'($urandom_range(1)), 31'h7F7F_FFFF};
    endcase
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_score(pick_score(), i == len - 1);
  endtask

  initial begin
    int sets;
    int len;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; stall_pct = 0; hold_req = 1'b0; quiet = 0; sent = 0;
    tie_pool = '{32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000,
                 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset k: lone final, mostly unfilled
    send_score(32'h4040_0000, 1'b1);
    // equal minima, NaN never replaces, strictly greater
    send_score(32'h3F80_0000, 1'b0);
    send_score(32'h3F80_0000, 1'b0);
    send_score(32'h3F80_0000, 1'b0);
    send_score(32'h4000_0000, 1'b0);
    send_score(32'h7FC0_0000, 1'b0);
    send_score(32'h3F80_0000, 1'b0);
    send_score(32'h4000_0000, 1'b1);
    // k = 0 behaves as one
    write_k(4'd0);
    send_score(32'h8000_0000, 1'b0);
    send_score(32'h0000_0000, 1'b0);
    send_score(32'h0000_0001, 1'b1);
    // k above max, NaN stored in fill phase, infinities
    write_k(4'd15);
    send_score(32'hFFFF_FFFF, 1'b0);
    send_score(32'hFF80_0000, 1'b0);
    send_score(32'h7F80_0000, 1'b0);
    send_score(32'h0000_0000, 1'b0);
    send_score(32'hFF7F_FFFF, 1'b0);
    send_score(32'h7FFF_FFFF, 1'b0);
    send_score(32'h8000_0001, 1'b0);
    send_score(32'h7F7F_FFFF, 1'b0);
    send_score(32'h0000_0000, 1'b1);
    // k changed mid-set
    write_k(4'd2);
    send_score(32'h4100_0000, 1'b0);
    send_score(32'h4000_0000, 1'b0);
    send_score(32'h4200_0000, 1'b0);
    write_k(4'd6);
    send_score(32'hC000_0000, 1'b0);
    send_score(32'h4080_0000, 1'b1);
    drop_valid();

    sets = 0;
    while (sent < 460) begin
      case ((sets / 3) % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        3: begin idle_pct = 14; stall_pct = 14; end
        default: begin idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
      endcase
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: write_k(4'd1);
          1: write_k(4'd8);
          default: write_k(4'($urandom));
        endcase
      end
      if (sets == 8) begin
        hold_req = 1'b1;
        idle_pct = 0;
        for (int r = 0; r < 5; r++) send_set(8);
      end
      if (sets == 14) begin
        idle_pct = 0;
        stall_pct = 0;
        send_set(MAX_SET_LEN + 4);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 12);
        send_set(len);
      end
      sets++;
      if ($urandom_range(5) == 0) drop_valid();
    end
    drop_valid();
    wait (pending == 0);
    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("top_k_score_selector regression: pass");
    else
      $display("top_k_score_selector regression: fail");
    $finish;
  end
endmodule
